### hdl/pat_pkg.sv
// shared widths, codes and defaults of the paged address translator
`timescale 1ns / 1ps
`default_nettype none
package pat_pkg;

	localparam int MAX_PROCS_DEF       = 16;
	localparam int MAX_FRAME_COUNT_DEF = 128;

	localparam int PID_W      = 5;
	localparam int VAL_W      = 16;
	localparam int PS_W       = 11;
	localparam int FC_W       = 8;
	localparam int PC_W       = 8;
	localparam int PN_W       = 16;
	localparam int OFF_W      = 10;
	localparam int FRAME_W    = 7;
	localparam int PHYS_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int DIV_W      = 17;

	localparam logic [PS_W-1:0] PAGE_SIZE_RESET   = 11'd128;
	localparam logic [PS_W-1:0] PAGE_SIZE_MAX     = 11'd1024;
	localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 8'd8;

	localparam logic CMD_ALLOCATE  = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_ID     = 3'd1,
		ST_NO_PAGES   = 3'd2,
		ST_BAD_ADDR   = 3'd3,
		ST_PAGE_FAULT = 3'd4,
		ST_NO_FRAMES  = 3'd5,
		ST_TABLE_FULL = 3'd6
	} status_t;

endpackage
`default_nettype wire

### hdl/pat_intf.sv
// request, response and configuration channels of the paged address translator
`timescale 1ns / 1ps
`default_nettype none
interface pat_req_if import pat_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PID_W-1:0] process_id;
	logic [VAL_W-1:0] size_or_address;

	modport source (output valid, cmd, process_id, size_or_address, input ready);
	modport sink   (input valid, cmd, process_id, size_or_address, output ready);
endinterface

interface pat_rsp_if import pat_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [PID_W-1:0]   process_id_out;
	logic [PC_W-1:0]    page_count;
	logic [PN_W-1:0]    page_number;
	logic [OFF_W-1:0]   page_offset;
	logic [FRAME_W-1:0] frame_number;
	logic [PHYS_W-1:0]  physical_address;

	modport source (output valid, status, process_id_out, page_count, page_number,
		page_offset, frame_number, physical_address, input ready);
	modport sink   (input valid, status, process_id_out, page_count, page_number,
		page_offset, frame_number, physical_address, output ready);
endinterface

interface pat_cfg_if import pat_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/paged_address_translator_core.sv
// paged address translator: process table memory, serial divider and result register
// sequence: an accepted request runs the 17-step restoring divider, then the evaluate state,
// and an ok translate also the multiply and add states; a bad id or a full table skips to done
// throughput: one transaction at a time; a new request is taken only once the result has moved
// into the response register, which waits while a previous response is held back by ready
// reset: counters clear, page size 128, frame count 8; the table memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
module paged_address_translator_core import pat_pkg::*; #(
	parameter int MAX_PROCS       = MAX_PROCS_DEF,
	parameter int MAX_FRAME_COUNT = MAX_FRAME_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pat_cfg_if.sink    cfg,
	pat_req_if.sink    req,
	pat_rsp_if.source  rsp
);

	localparam int AW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW  = $clog2(MAX_PROCS + 1);
	localparam int DCW = $clog2(DIV_W);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_W - 1);
	localparam logic [FC_W-1:0] FC_CAP =
		(MAX_FRAME_COUNT > 255) ? 8'd255 : FC_W'(MAX_FRAME_COUNT);

	typedef struct packed {
		logic [VAL_W-1:0]   size;
		logic [FRAME_W-1:0] base;
		logic [PC_W-1:0]    pages;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_EVAL,
		S_MUL,
		S_ADD,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [PS_W-1:0]    page_size_q;
	logic [FC_W-1:0]    frame_count_q;
	logic [CW-1:0]      proc_count_q;
	logic [FC_W-1:0]    next_frame_q;
	logic [DCW-1:0]     cnt_q;
	logic               rsp_valid_q;

	logic               cmd_q;
	logic [VAL_W-1:0]   val_q;
	logic [PS_W-1:0]    ps_q;
	logic [DIV_W-1:0]   quo_q;
	logic [PS_W-1:0]    rem_q;
	entry_t             rd_q;
	logic [FRAME_W-1:0] frame_q;
	logic [17:0]        prod_q;

	status_t            res_status_q;
	logic [PID_W-1:0]   res_pid_q;
	logic [PC_W-1:0]    res_pc_q;
	logic [PN_W-1:0]    res_pn_q;
	logic [OFF_W-1:0]   res_off_q;
	logic [FRAME_W-1:0] res_frame_q;
	logic [PHYS_W-1:0]  res_phys_q;

	status_t            rsp_status_q;
	logic [PID_W-1:0]   rsp_pid_q;
	logic [PC_W-1:0]    rsp_pc_q;
	logic [PN_W-1:0]    rsp_pn_q;
	logic [OFF_W-1:0]   rsp_off_q;
	logic [FRAME_W-1:0] rsp_frame_q;
	logic [PHYS_W-1:0]  rsp_phys_q;

	entry_t             mem [MAX_PROCS];

	logic               req_acc;
	logic               cfg_acc;
	logic [PS_W-1:0]    eff_ps;
	logic [FC_W-1:0]    eff_fc;
	logic [5:0]         pid_m1;
	logic [AW-1:0]      rd_idx;
	logic [AW-1:0]      wr_idx;
	logic               bad_id;
	logic               table_full;
	logic               early_fail;
	logic [PS_W:0]      div_trial;
	logic               div_ge;
	logic [17:0]        alloc_end;
	logic               no_room;
	logic               alloc_eval;
	entry_t             wr_entry;
	logic [FRAME_W-1:0] xl_frame;
	logic               xl_ok;
	logic               rsp_free;

	assign req_acc = req.valid && req.ready;
	assign cfg_acc = cfg.valid && cfg.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		if (page_size_q == '0) begin
			eff_ps = 11'd1;
		end else if (page_size_q > PAGE_SIZE_MAX) begin
			eff_ps = PAGE_SIZE_MAX;
		end else begin
			eff_ps = page_size_q;
		end
	end

	assign eff_fc = (frame_count_q > FC_CAP) ? FC_CAP : frame_count_q;

	assign pid_m1 = {1'b0, req.process_id} - 6'd1;
	assign rd_idx = AW'(pid_m1);
	assign wr_idx = AW'(proc_count_q);

	assign bad_id = (req.process_id == '0)
		|| (32'(req.process_id) > 32'(proc_count_q))
		|| (32'(req.process_id) > 32'(MAX_PROCS));
	assign table_full = (32'(proc_count_q) >= 32'(MAX_PROCS));
	assign early_fail = (req.cmd == CMD_TRANSLATE) ? bad_id : table_full;

	// one restoring step per cycle
	assign div_trial = {rem_q, quo_q[DIV_W-1]};
	assign div_ge    = (div_trial >= {1'b0, ps_q});

	assign alloc_end  = {10'b0, next_frame_q} + {1'b0, quo_q};
	assign no_room    = (alloc_end > {10'b0, eff_fc});
	assign alloc_eval = (state_q == S_EVAL) && (cmd_q == CMD_ALLOCATE);

	always_comb begin
		wr_entry.size  = val_q;
		wr_entry.base  = no_room ? '0 : next_frame_q[FRAME_W-1:0];
		wr_entry.pages = no_room ? '0 : quo_q[PC_W-1:0];
	end

	assign xl_frame = FRAME_W'(rd_q.base + quo_q[FRAME_W-1:0]);
	assign xl_ok    = (rd_q.pages != '0) && (val_q < rd_q.size)
		&& (quo_q < {9'b0, rd_q.pages});

	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (alloc_eval) begin
			mem[wr_idx] <= wr_entry;
		end
		if (req_acc) begin
			rd_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			page_size_q   <= PAGE_SIZE_RESET;
			frame_count_q <= FRAME_COUNT_RESET;
			proc_count_q  <= '0;
			next_frame_q  <= '0;
			cnt_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg.index)
					REG_PAGE_SIZE:   page_size_q   <= cfg.data;
					REG_FRAME_COUNT: frame_count_q <= cfg.data[FC_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						cnt_q   <= '0;
						state_q <= early_fail ? S_DONE : S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (cmd_q == CMD_ALLOCATE) begin
						proc_count_q <= proc_count_q + 1'b1;
						if (!no_room) begin
							next_frame_q <= alloc_end[FC_W-1:0];
						end
						state_q <= S_DONE;
					end else begin
						state_q <= xl_ok ? S_MUL : S_DONE;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					cmd_q       <= req.cmd;
					val_q       <= req.size_or_address;
					ps_q        <= eff_ps;
					rem_q       <= '0;
					quo_q       <= (req.cmd == CMD_TRANSLATE) ? {1'b0, req.size_or_address}
						: {1'b0, req.size_or_address} + {6'b0, eff_ps} - 17'd1;
					res_pc_q    <= '0;
					res_pn_q    <= '0;
					res_off_q   <= '0;
					res_frame_q <= '0;
					res_phys_q  <= '0;
					if (req.cmd == CMD_TRANSLATE) begin
						res_pid_q    <= req.process_id;
						res_status_q <= ST_BAD_ID;
					end else begin
						res_pid_q    <= table_full ? '0 : PID_W'(32'(proc_count_q) + 32'd1);
						res_status_q <= ST_TABLE_FULL;
					end
				end
			end
			S_DIV: begin
				quo_q <= {quo_q[DIV_W-2:0], div_ge};
				rem_q <= div_ge ? PS_W'(div_trial - {1'b0, ps_q}) : div_trial[PS_W-1:0];
			end
			S_EVAL: begin
				if (cmd_q == CMD_ALLOCATE) begin
					if (no_room) begin
						res_status_q <= ST_NO_FRAMES;
					end else begin
						res_status_q <= ST_OK;
						res_pc_q     <= quo_q[PC_W-1:0];
						res_frame_q  <= (quo_q != '0) ? next_frame_q[FRAME_W-1:0] : '0;
					end
				end else begin
					frame_q <= xl_frame;
					if (rd_q.pages == '0) begin
						res_status_q <= ST_NO_PAGES;
					end else if (val_q >= rd_q.size) begin
						res_status_q <= ST_BAD_ADDR;
					end else if (!xl_ok) begin
						res_status_q <= ST_PAGE_FAULT;
					end else begin
						res_status_q <= ST_OK;
						res_pn_q     <= quo_q[PN_W-1:0];
						res_off_q    <= rem_q[OFF_W-1:0];
						res_frame_q  <= xl_frame;
					end
				end
			end
			S_MUL: begin
				prod_q <= {11'b0, frame_q} * {7'b0, ps_q};
			end
			S_ADD: begin
				res_phys_q <= PHYS_W'(prod_q + {8'b0, res_off_q});
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_status_q <= res_status_q;
					rsp_pid_q    <= res_pid_q;
					rsp_pc_q     <= res_pc_q;
					rsp_pn_q     <= res_pn_q;
					rsp_off_q    <= res_off_q;
					rsp_frame_q  <= res_frame_q;
					rsp_phys_q   <= res_phys_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.process_id_out   = rsp_pid_q;
	assign rsp.page_count       = rsp_pc_q;
	assign rsp.page_number      = rsp_pn_q;
	assign rsp.page_offset      = rsp_off_q;
	assign rsp.frame_number     = rsp_frame_q;
	assign rsp.physical_address = rsp_phys_q;

endmodule
`default_nettype wire

### sim/tb_paged_address_translator_core.sv
// testbench of the paged address translator: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module tb_paged_address_translator_core import pat_pkg::*;;

	localparam int RESET_CYCLES    = 10;
	localparam int SETTLE_CYCLES   = 30;
	localparam int QUIET_LIMIT     = 2000;
	localparam int LONG_HOLD       = 300;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 104;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_t;

	typedef struct packed {
		status_t              status;
		logic [PID_W-1:0]     pid;
		logic [PC_W-1:0]      pages;
		logic [PN_W-1:0]      page;
		logic [OFF_W-1:0]     offset;
		logic [FRAME_W-1:0]   frame;
		logic [PHYS_W-1:0]    phys;
	} paging_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pat_cfg_if cfg_ch ();
	pat_req_if req_ch ();
	pat_rsp_if rsp_ch ();

	paged_address_translator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	paging_result_t pending_results[$];

	logic [PS_W-1:0] page_size_reg   = PAGE_SIZE_RESET;
	logic [FC_W-1:0] frame_count_reg = FRAME_COUNT_RESET;
	int unsigned     slots_taken     = 0;
	int unsigned     free_frame      = 0;
	int unsigned     slot_size[MAX_PROCS_DEF];
	int unsigned     slot_base[MAX_PROCS_DEF];
	int unsigned     slot_pages[MAX_PROCS_DEF];

	int   mismatch_count = 0;
	int   burst_left     = 0;
	int   quiet_cycles   = 0;
	int   hold_requests  = 0;

	function automatic paging_result_t predict_result(input logic cmd,
		input logic [PID_W-1:0] pid, input logic [VAL_W-1:0] val);
		paging_result_t r;
		int unsigned ps, fc, pages, idx, page, offset, frame;
		r = '0;
		ps = 32'(page_size_reg);
		if (ps == 0) ps = 1;
		else if (ps > PAGE_SIZE_MAX) ps = 32'(PAGE_SIZE_MAX);
		fc = 32'(frame_count_reg);
		if (fc > MAX_FRAME_COUNT_DEF) fc = MAX_FRAME_COUNT_DEF;
		if (cmd == CMD_ALLOCATE) begin
			if (slots_taken >= MAX_PROCS_DEF) begin
				r.status = ST_TABLE_FULL;
				return r;
			end
			idx = slots_taken;
			pages = (32'(val) + ps - 1) / ps;
			slot_size[idx] = 32'(val);
			slots_taken = idx + 1;
			r.pid = PID_W'(idx + 1);
			if (free_frame + pages > fc) begin
				slot_base[idx] = 0;
				slot_pages[idx] = 0;
				r.status = ST_NO_FRAMES;
				return r;
			end
			slot_base[idx] = free_frame & 'h7F;
			slot_pages[idx] = pages & 'hFF;
			r.status = ST_OK;
			r.pages = PC_W'(pages);
			if (pages != 0) r.frame = FRAME_W'(free_frame);
			free_frame = (free_frame + pages) & 'hFF;
			return r;
		end
		r.pid = pid;
		if (pid == 0 || 32'(pid) > slots_taken) begin
			r.status = ST_BAD_ID;
			return r;
		end
		idx = 32'(pid) - 1;
		if (slot_pages[idx] == 0) begin
			r.status = ST_NO_PAGES;
			return r;
		end
		if (32'(val) >= slot_size[idx]) begin
			r.status = ST_BAD_ADDR;
			return r;
		end
		page = 32'(val) / ps;
		offset = 32'(val) % ps;
		if (page >= slot_pages[idx]) begin
			r.status = ST_PAGE_FAULT;
			return r;
		end
		frame = (slot_base[idx] + page) & 'h7F;
		r.status = ST_OK;
		r.page = PN_W'(page);
		r.offset = OFF_W'(offset);
		r.frame = FRAME_W'(frame);
		r.phys = PHYS_W'(frame * ps + offset);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	task automatic send_request(input logic cmd, input logic [PID_W-1:0] pid,
		input logic [VAL_W-1:0] val);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid = 1'b1;
		req_ch.cmd = cmd;
		req_ch.process_id = pid;
		req_ch.size_or_address = val;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_result(cmd, pid, val));
	endtask

	task automatic drain_pending();
		@(negedge clk);
		req_ch.valid = 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_PAGE_SIZE) page_size_reg = data;
		else if (idx == REG_FRAME_COUNT) frame_count_reg = data[FC_W-1:0];
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] ps,
		input logic [CFG_DATA_W-1:0] fc);
		drain_pending();
		if ($urandom_range(0, 1)) begin
			write_register(REG_PAGE_SIZE, ps);
			write_register(REG_FRAME_COUNT, fc);
		end else begin
			write_register(REG_FRAME_COUNT, fc);
			write_register(REG_PAGE_SIZE, ps);
		end
	endtask

	task automatic send_random_translate();
		logic [PID_W-1:0] pid;
		logic [VAL_W-1:0] addr;
		int unsigned      span;
		if (slots_taken != 0 && $urandom_range(0, 99) < 80)
			pid = PID_W'($urandom_range(1, slots_taken));
		else
			pid = PID_W'($urandom_range(0, 31));
		addr = VAL_W'($urandom_range(0, 65535));
		if (pid != 0 && 32'(pid) <= slots_taken && $urandom_range(0, 99) < 75) begin
			span = slot_size[32'(pid) - 1];
			if (span != 0) begin
				case ($urandom_range(0, 5))
					0: addr = VAL_W'(span - 1);
					1: addr = VAL_W'(span);
					default: addr = VAL_W'($urandom_range(0, span - 1));
				endcase
			end
		end
		send_request(CMD_TRANSLATE, pid, addr);
	endtask

	// reset values, nothing allocated yet
	task automatic test_empty_table();
		send_request(CMD_TRANSLATE, 5'd0, 16'd0);
		send_request(CMD_TRANSLATE, 5'd1, 16'd0);
		send_request(CMD_TRANSLATE, 5'd31, 16'hFFFF);
	endtask

	// page size 128, 8 frames: zero size, refused and exact fill
	task automatic test_reset_config_allocation();
		send_request(CMD_ALLOCATE, 5'd0, 16'd0);
		send_request(CMD_TRANSLATE, 5'd1, 16'd0);
		send_request(CMD_ALLOCATE, 5'd31, 16'd300);
		send_request(CMD_TRANSLATE, 5'd2, 16'd0);
		send_request(CMD_TRANSLATE, 5'd2, 16'd299);
		send_request(CMD_TRANSLATE, 5'd2, 16'd300);
		send_request(CMD_ALLOCATE, 5'd7, 16'hFFFF);
		send_request(CMD_TRANSLATE, 5'd3, 16'd10);
		send_request(CMD_ALLOCATE, 5'd0, 16'd640);
		send_request(CMD_ALLOCATE, 5'd0, 16'd1);
		send_request(CMD_TRANSLATE, 5'd4, 16'd639);
		send_request(CMD_TRANSLATE, 5'd6, 16'd0);
	endtask

	task automatic test_largest_page();
		set_config(11'd1024, 11'h7FF);
		send_request(CMD_ALLOCATE, 5'd0, 16'hFFFF);
		send_request(CMD_TRANSLATE, 5'd6, 16'hFFFF);
		send_request(CMD_TRANSLATE, 5'd6, 16'd0);
	endtask

	// page size shrunk after allocation, zero frames
	task automatic test_page_fault_after_resize();
		set_config(11'd0, 11'd0);
		send_request(CMD_TRANSLATE, 5'd2, 16'd5);
		send_request(CMD_TRANSLATE, 5'd2, 16'd2);
		send_request(CMD_ALLOCATE, 5'd0, 16'd0);
	endtask

	task automatic test_oversized_page_size();
		set_config(11'h7FF, 11'd128);
		send_request(CMD_TRANSLATE, 5'd6, 16'd1024);
		send_request(CMD_TRANSLATE, 5'd4, 16'd100);
	endtask

	task automatic test_response_backpressure();
		drain_pending();
		hold_requests++;
		repeat (20) send_random_translate();
	endtask

	task automatic test_random_mix();
		logic [CFG_DATA_W-1:0] ps, fc;
		logic [VAL_W-1:0]      alloc_size;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 4))
				0: ps = CFG_DATA_W'($urandom_range(1, 16));
				1: ps = CFG_DATA_W'(1 << $urandom_range(0, 10));
				2: ps = CFG_DATA_W'($urandom_range(0, 1024));
				3: ps = CFG_DATA_W'($urandom_range(1025, 2047));
				default: ps = CFG_DATA_W'($urandom_range(17, 400));
			endcase
			fc = $urandom_range(0, 1) ? 11'd128 : CFG_DATA_W'($urandom_range(0, 2047));
			set_config(ps, fc);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) < 8) begin
					case ($urandom_range(0, 3))
						0: alloc_size = VAL_W'($urandom_range(0, 16));
						1: alloc_size = VAL_W'($urandom_range(0, 4096));
						2: alloc_size = VAL_W'($urandom_range(0, 65535));
						default: alloc_size = VAL_W'($urandom_range(0, 2048));
					endcase
					send_request(CMD_ALLOCATE, PID_W'($urandom_range(0, 31)), alloc_size);
				end else begin
					send_random_translate();
				end
			end
		end
	endtask

	initial begin : response_acceptor
		rx_mode_t mode;
		int       mode_left;
		int       tick;
		int       holds_done;
		mode = RX_ALWAYS;
		mode_left = 0;
		tick = 0;
		holds_done = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				rsp_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			tick++;
			case (mode)
				RX_ALWAYS:   rsp_ch.ready = 1'b1;
				RX_COIN:     rsp_ch.ready = 1'($urandom_range(0, 1));
				RX_PERIODIC: rsp_ch.ready = (tick % 4 == 0);
				default:     rsp_ch.ready = ($urandom_range(0, 99) < 85);
			endcase
		end
	end

	always @(posedge clk) begin : check_responses
		paging_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction with status %0d",
					rsp_ch.status));
			end else begin
				want = pending_results.pop_front();
				compare_field("status", 32'(rsp_ch.status), 32'(want.status));
				compare_field("process_id_out", 32'(rsp_ch.process_id_out), 32'(want.pid));
				compare_field("page_count", 32'(rsp_ch.page_count), 32'(want.pages));
				compare_field("page_number", 32'(rsp_ch.page_number), 32'(want.page));
				compare_field("page_offset", 32'(rsp_ch.page_offset), 32'(want.offset));
				compare_field("frame_number", 32'(rsp_ch.frame_number), 32'(want.frame));
				compare_field("physical_address", 32'(rsp_ch.physical_address),
					32'(want.phys));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ALLOCATE;
		req_ch.process_id = '0;
		req_ch.size_or_address = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_PAGE_SIZE;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_reset_config_allocation();
		test_largest_page();
		test_page_fault_after_resize();
		test_oversized_page_size();
		test_response_backpressure();
		test_random_mix();
		drain_pending();

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
hdl/pat_pkg.sv
hdl/pat_intf.sv
hdl/paged_address_translator_core.sv
sim/tb_paged_address_translator_core.sv
